[src/taab_pkg.sv]
// Package for the timestamp aligned audio buffer: payload structs, codes,
// controller/datapath command and status types. No dependencies.
package taab_pkg;

    localparam int DEPTH_DEF    = 1024;
    localparam int CHANNELS_DEF = 2;
    localparam int CAP_W        = 11;
    localparam int PTS_W        = 64;
    localparam int SMP_W        = 32;

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_DROP = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_STALE    = 3'd1;
    localparam logic [2:0] ST_CAPACITY = 3'd2;
    localparam logic [2:0] ST_BACKWARD = 3'd3;
    localparam logic [2:0] ST_BAD_PTS  = 3'd4;

    typedef struct packed {
        logic [1:0]       func;
        logic             pts_valid;
        logic [PTS_W-1:0] pts;
        logic [SMP_W-1:0] sample_a;
        logic [SMP_W-1:0] sample_b;
    } t_in_req;

    typedef struct packed {
        logic [2:0]       status;
        logic             filled;
        logic [SMP_W-1:0] out_sample_a;
        logic [SMP_W-1:0] out_sample_b;
        logic [CAP_W-1:0] buffered_count;
    } t_out_req;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input request
        logic rd_head;   // issue memory read at head
        logic pop;       // advance head, decrement count
        logic write;     // store at tail
        logic set_acc;   // update accepted horizon
        logic set_rd;    // update read horizon
        logic take;      // latch head sample as read result
        logic [2:0] status;
        logic emit;      // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic bad_pts;   // missing or largest timestamp
        logic stale;
        logic backward;
        logic full;      // count >= effective capacity
        logic empty;
        logic head_lt;   // head pts below request pts
        logic head_eq;
        logic out_busy;
    } t_sts;

endpackage

[src/taab_datapath.sv]
// Datapath: frame memories, head/tail pointers, count, horizons, output register.
// Depends on taab_pkg.
module taab_datapath #(
    parameter int DEPTH    = taab_pkg::DEPTH_DEF,
    parameter int CHANNELS = taab_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [taab_pkg::CAP_W-1:0]    i_cfg_data,
    input  taab_pkg::t_in_req             i_req,
    input  taab_pkg::t_cmd                i_cmd,
    output taab_pkg::t_sts                o_sts,
    output logic                          o_valid,
    input  logic                          i_ready,
    output taab_pkg::t_out_req            o_res
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [taab_pkg::PTS_W-1:0] PTS_MAX = {1'b0, {(taab_pkg::PTS_W-1){1'b1}}};

    logic [taab_pkg::PTS_W-1:0] r_pts_mem [DEPTH];
    logic [2*taab_pkg::SMP_W-1:0] r_smp_mem [DEPTH];

    taab_pkg::t_in_req r_req;
    logic [AW-1:0] r_head, r_tail;
    logic [CW-1:0] r_count;
    logic [taab_pkg::CAP_W-1:0] r_cap;
    logic [taab_pkg::PTS_W-1:0] r_acc, r_rdh, r_head_pts;
    logic [2*taab_pkg::SMP_W-1:0] r_head_smp, r_word;
    logic r_acc_v, r_rdh_v, r_filled, r_valid;
    taab_pkg::t_out_req r_res;

    logic [CW-1:0] eff_cap;
    logic [taab_pkg::PTS_W-1:0] pts_inc;

    function automatic logic lt_s(input logic [taab_pkg::PTS_W-1:0] a,
                                  input logic [taab_pkg::PTS_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
        return (32'(i) + 32'd1 >= 32'(DEPTH)) ? '0 : AW'(32'(i) + 32'd1);
    endfunction

    // clamp capacity to 1..DEPTH
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CW'(1);
        end else if (32'(r_cap) > 32'(DEPTH)) begin
            eff_cap = DEPTH_C;
        end else begin
            eff_cap = CW'(r_cap);
        end
    end

    assign pts_inc = r_req.pts + taab_pkg::PTS_W'(1);

    // status toward controller; the largest timestamp is never below a horizon,
    // so a read of it is rejected as bad whatever the read horizon holds
    always_comb begin
        o_sts.func     = r_req.func;
        o_sts.bad_pts  = !r_req.pts_valid || (r_req.pts == PTS_MAX);
        o_sts.stale    = (r_acc_v && lt_s(r_req.pts, r_acc)) ||
                         (r_rdh_v && lt_s(r_req.pts, r_rdh));
        o_sts.backward = (r_rdh_v && lt_s(r_req.pts, r_rdh));
        o_sts.full     = 32'(r_count) >= 32'(eff_cap);
        o_sts.empty    = r_count == '0;
        o_sts.head_lt  = lt_s(r_head_pts, r_req.pts);
        o_sts.head_eq  = r_head_pts == r_req.pts;
        o_sts.out_busy = r_valid && !i_ready;
    end

    // memories: registered read at head, write at tail
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_pts_mem[r_tail] <= r_req.pts;
            r_smp_mem[r_tail] <= (CHANNELS > 1) ? {r_req.sample_b, r_req.sample_a}
                                                : {{taab_pkg::SMP_W{1'b0}}, r_req.sample_a};
        end
        if (i_cmd.rd_head) begin
            r_head_pts <= r_pts_mem[r_head];
            r_head_smp <= r_smp_mem[r_head];
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.load) begin
            r_word <= '0;
        end else if (i_cmd.take) begin
            r_word <= r_head_smp;
        end
        if (i_cmd.emit) begin
            r_res.status         <= i_cmd.status;
            r_res.filled         <= r_filled;
            r_res.out_sample_a   <= r_word[taab_pkg::SMP_W-1:0];
            r_res.out_sample_b   <= r_word[2*taab_pkg::SMP_W-1:taab_pkg::SMP_W];
            r_res.buffered_count <= taab_pkg::CAP_W'(r_count);
        end
        if (i_cmd.set_acc) r_acc <= pts_inc;
        if (i_cmd.set_rd)  r_rdh <= pts_inc;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_cap    <= taab_pkg::CAP_W'(1024);
            r_acc_v  <= 1'b0;
            r_rdh_v  <= 1'b0;
            r_filled <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (i_cmd.pop) r_head <= nxt(r_head);
            if (i_cmd.write) r_tail <= nxt(r_tail);
            if (i_cmd.write && !i_cmd.pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop && !i_cmd.write) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.set_acc) r_acc_v <= 1'b1;
            if (i_cmd.set_rd)  r_rdh_v <= 1'b1;
            if (i_cmd.load) begin
                r_filled <= 1'b0;
            end else if (i_cmd.take) begin
                r_filled <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

[src/taab_ctrl.sv]
// Controller state machine: sequences push, drop-oldest and read requests.
// Depends on taab_pkg.
module taab_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  taab_pkg::t_sts i_sts,
    output taab_pkg::t_cmd o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DEC   = 6'b000010,
        S_EVICT = 6'b000100,
        S_WAIT  = 6'b001000,
        S_SCAN  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= taab_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_ready = i_rst_n && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.rd_head = 1'b1;
                n_status = taab_pkg::ST_OK;
                n_state  = S_EMIT;
                case (i_sts.func)
                    taab_pkg::FUNC_PUSH, taab_pkg::FUNC_DROP: begin
                        if (i_sts.bad_pts) begin
                            n_status = taab_pkg::ST_BAD_PTS;
                        end else if (i_sts.stale) begin
                            n_status = taab_pkg::ST_STALE;
                        end else if (i_sts.full && i_sts.func == taab_pkg::FUNC_PUSH) begin
                            n_status = taab_pkg::ST_CAPACITY;
                        end else if (i_sts.full) begin
                            n_state = S_EVICT;
                        end else begin
                            o_cmd.write   = 1'b1;
                            o_cmd.set_acc = 1'b1;
                        end
                    end
                    taab_pkg::FUNC_READ: begin
                        if (i_sts.bad_pts) begin
                            n_status = taab_pkg::ST_BAD_PTS;
                        end else if (i_sts.backward) begin
                            n_status = taab_pkg::ST_BACKWARD;
                        end else if (i_sts.empty) begin
                            o_cmd.set_rd = 1'b1;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: n_status = taab_pkg::ST_OK;
                endcase
            end
            // drop head frames until there is room, then store
            S_EVICT: begin
                if (i_sts.full) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    o_cmd.write   = 1'b1;
                    o_cmd.set_acc = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            // let the memory read at the new head settle
            S_WAIT: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.empty) begin
                    o_cmd.set_rd = 1'b1;
                    n_state      = S_EMIT;
                end else if (i_sts.head_lt) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_WAIT;
                end else begin
                    if (i_sts.head_eq) begin
                        o_cmd.take = 1'b1;
                        o_cmd.pop  = 1'b1;
                    end
                    o_cmd.set_rd = 1'b1;
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[src/timestamp_aligned_audio_buffer_core.sv]
// Top level of the timestamp aligned audio buffer.
// Depends on taab_pkg, taab_ctrl, taab_datapath.
//
//  channel | signals                       | handshake
//  input   | i_in_valid/o_in_ready/i_in    | valid-ready
//  output  | o_out_valid/i_out_ready/o_out | valid-ready
//  config  | i_cfg_we/i_cfg_data           | write enable, no wait
//
// A request passes through accept, decode and emit before the next one can be
// accepted; its result is valid in the cycle after emit. A push that evicts adds
// an evict state that drops head frames one at a time, then stores; a read of a
// non-empty buffer scans with a wait per stale frame for the registered read port.
// Reset is synchronous and active low; the memories need no clearing.
// A result waiting in the output register holds the controller in emit, so the
// input stays stalled until that result is taken.
module timestamp_aligned_audio_buffer_core #(
    parameter int DEPTH    = taab_pkg::DEPTH_DEF,
    parameter int CHANNELS = taab_pkg::CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [taab_pkg::CAP_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  taab_pkg::t_in_req          i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output taab_pkg::t_out_req         o_out
);
    taab_pkg::t_cmd cmd;
    taab_pkg::t_sts sts;

    taab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    taab_datapath #(.DEPTH(DEPTH), .CHANNELS(CHANNELS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (o_out)
    );
endmodule

[tb/sv/tb.sv]
// Testbench for timestamp_aligned_audio_buffer_core: random and directed requests,
// a behavioral predictor of the frame buffer, and a field-by-field result check.
// Depends on taab_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = taab_pkg::DEPTH_DEF;
    localparam int CAP_W = taab_pkg::CAP_W;
    localparam logic [63:0] PTS_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PTS_BOTTOM = 64'h8000_0000_0000_0000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int unsigned RX_STALL_CYCLES = 400;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CAP_W-1:0] i_cfg_data;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    taab_pkg::t_in_req i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    taab_pkg::t_out_req o_out;

    timestamp_aligned_audio_buffer_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    // Predictor state of the frame buffer
    logic [63:0] pts_mem [DEPTH];
    logic [63:0] smp_mem [DEPTH];
    int unsigned head_ptr, tail_ptr, held;
    logic [63:0] acc_hzn, rd_hzn;
    logic acc_hzn_ok, rd_hzn_ok;
    logic [CAP_W-1:0] capacity_reg;

    taab_pkg::t_in_req pending_reqs[$];
    taab_pkg::t_out_req expected_results[$];
    int errors = 0;
    bit tx_quiet, rx_quiet;
    bit sender_hold;
    bit rx_long_stall;
    bit rx_stall_done = 1'b0;
    bit in_fire = 1'b0;
    int unsigned rx_stall_cnt = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned idle_cycles = 0;

    // The stimulus side tracks the read horizon to avoid reads of unwritten entries;
    // the predictor itself never reads an entry beyond the held count.
    function automatic bit pts_lt(logic [63:0] a, logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic int unsigned cap_now();
        int unsigned c;
        c = capacity_reg;
        if (c == 0) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic void drop_head();
        if (held == 0) return;
        head_ptr = (head_ptr + 1) % DEPTH;
        held--;
    endfunction

    function automatic void queue_req(taab_pkg::t_in_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    // Apply one request to the predictor and return the expected result
    function automatic taab_pkg::t_out_req buffer_step(taab_pkg::t_in_req r);
        taab_pkg::t_out_req res;
        logic [63:0] word;
        res = '0;
        word = '0;
        if (r.func == taab_pkg::FUNC_PUSH || r.func == taab_pkg::FUNC_DROP) begin
            if (!r.pts_valid || r.pts == PTS_TOP) begin
                res.status = taab_pkg::ST_BAD_PTS;
            end else if ((acc_hzn_ok && pts_lt(r.pts, acc_hzn)) ||
                         (rd_hzn_ok && pts_lt(r.pts, rd_hzn))) begin
                res.status = taab_pkg::ST_STALE;
            end else if (r.func == taab_pkg::FUNC_PUSH && held >= cap_now()) begin
                res.status = taab_pkg::ST_CAPACITY;
            end else begin
                while (held >= cap_now()) drop_head();
                pts_mem[tail_ptr] = r.pts;
                smp_mem[tail_ptr] = {r.sample_b, r.sample_a};
                tail_ptr = (tail_ptr + 1) % DEPTH;
                held++;
                acc_hzn = r.pts + 64'd1;
                acc_hzn_ok = 1'b1;
                res.status = taab_pkg::ST_OK;
            end
        end else if (r.func == taab_pkg::FUNC_READ) begin
            if (!r.pts_valid) begin
                res.status = taab_pkg::ST_BAD_PTS;
            end else if (rd_hzn_ok && pts_lt(r.pts, rd_hzn)) begin
                res.status = taab_pkg::ST_BACKWARD;
            end else if (r.pts == PTS_TOP) begin
                res.status = taab_pkg::ST_BAD_PTS;
            end else begin
                while (held > 0 && pts_lt(pts_mem[head_ptr], r.pts)) drop_head();
                if (held > 0 && pts_mem[head_ptr] == r.pts) begin
                    word = smp_mem[head_ptr];
                    res.filled = 1'b1;
                    res.out_sample_a = word[31:0];
                    res.out_sample_b = word[63:32];
                    drop_head();
                end
                rd_hzn = r.pts + 64'd1;
                rd_hzn_ok = 1'b1;
                res.status = taab_pkg::ST_OK;
            end
        end
        res.buffered_count = CAP_W'(held);
        return res;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Record whether the request on offer was taken at the last rising edge
    always @(posedge i_clk) begin
        in_fire <= i_in_valid && o_in_ready;
    end

    // Drive requests at the falling edge from the pending queue
    always @(negedge i_clk) begin
        if (i_in_valid && !in_fire) begin
            // hold until accepted
        end else if (!i_rst_n || sender_hold) begin
            i_in_valid <= 1'b0;
        end else if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            i_in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            i_in <= pending_reqs[0];
            pending_reqs.delete(0);
            i_in_valid <= 1'b1;
            if (!tx_quiet && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 17);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver readiness, with random bursts and one long stall counted here
    always @(negedge i_clk) begin
        if (rx_stall_cnt > 0) begin
            rx_stall_cnt <= rx_stall_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (rx_long_stall && !rx_stall_done) begin
            rx_stall_cnt <= RX_STALL_CYCLES;
            rx_stall_done <= 1'b1;
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_out_ready <= 1'b0;
        end else if (!rx_quiet && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(0, 16);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        taab_pkg::t_out_req exp_res;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_results.insert(expected_results.size(), buffer_step(i_in));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: %p", $realtime, o_out);
                    errors++;
                end else begin
                    exp_res = expected_results[0];
                    expected_results.delete(0);
                    if (o_out.status !== exp_res.status) begin
                        $display("%0t: status exp %0d got %0d", $realtime,
                                 exp_res.status, o_out.status);
                        errors++;
                    end
                    if (o_out.filled !== exp_res.filled) begin
                        $display("%0t: filled exp %0d got %0d", $realtime,
                                 exp_res.filled, o_out.filled);
                        errors++;
                    end
                    if (o_out.out_sample_a !== exp_res.out_sample_a) begin
                        $display("%0t: sample_a exp %h got %h", $realtime,
                                 exp_res.out_sample_a, o_out.out_sample_a);
                        errors++;
                    end
                    if (o_out.out_sample_b !== exp_res.out_sample_b) begin
                        $display("%0t: sample_b exp %h got %h", $realtime,
                                 exp_res.out_sample_b, o_out.out_sample_b);
                        errors++;
                    end
                    if (o_out.buffered_count !== exp_res.buffered_count) begin
                        $display("%0t: count exp %0d got %0d", $realtime,
                                 exp_res.buffered_count, o_out.buffered_count);
                        errors++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Stimulus state: next push timestamp and read cursor
    logic [63:0] push_pts, read_pts;

    function automatic taab_pkg::t_in_req make_req(logic [1:0] f, logic v, logic [63:0] p);
        taab_pkg::t_in_req r;
        r.func = f;
        r.pts_valid = v;
        r.pts = p;
        r.sample_a = $urandom();
        r.sample_b = $urandom();
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        // let an evicting or popping request finish before a register write
        repeat (2 * DEPTH + 20) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] c);
        @(negedge i_clk);
        i_cfg_data <= c;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        capacity_reg = c;
    endtask

    // Queue one random request; mostly in-order pushes and reads
    task automatic add_random_req();
        int unsigned sel;
        logic [63:0] p;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            push_pts = push_pts + $urandom_range(0, 3);
            queue_req(make_req(2'($urandom_range(0, 1)), 1'b1, push_pts));
            push_pts = push_pts + 1;
        end else if (sel < 80) begin
            read_pts = read_pts + $urandom_range(0, 4);
            queue_req(make_req(taab_pkg::FUNC_READ, 1'b1, read_pts));
            read_pts = read_pts + 1;
            if (pts_lt(push_pts, read_pts)) push_pts = read_pts;
        end else if (sel < 88) begin
            // stale push or backward read
            p = read_pts - $urandom_range(1, 50);
            queue_req(make_req(2'($urandom_range(0, 2)), 1'b1, p));
        end else if (sel < 93) begin
            queue_req(make_req(2'($urandom_range(0, 2)), 1'b0, {$urandom(), $urandom()}));
        end else if (sel < 96) begin
            queue_req(make_req(FUNC_UNUSED, 1'($urandom_range(0, 1)),
                               {$urandom(), $urandom()}));
        end else begin
            // large or extreme timestamps, kept stale or invalid where they would wreck
            // the ordering of the sequence
            p = {$urandom(), $urandom()};
            if (!pts_lt(p, read_pts)) p = PTS_TOP;
            queue_req(make_req(2'($urandom_range(0, 2)), 1'b1, p));
        end
    endtask

    initial begin
        taab_pkg::t_in_req r;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        sender_hold = 1'b0;
        rx_long_stall = 1'b0;
        head_ptr = 0; tail_ptr = 0; held = 0;
        acc_hzn = '0; rd_hzn = '0;
        acc_hzn_ok = 1'b0; rd_hzn_ok = 1'b0;
        capacity_reg = 11'd1024;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every operation and special cases at reset capacity
        queue_req(make_req(taab_pkg::FUNC_PUSH, 1'b0, 64'd5));
        queue_req(make_req(taab_pkg::FUNC_READ, 1'b0, 64'd5));
        queue_req(make_req(taab_pkg::FUNC_PUSH, 1'b1, PTS_TOP));
        queue_req(make_req(FUNC_UNUSED, 1'b1, 64'd9));
        r = make_req(taab_pkg::FUNC_PUSH, 1'b1, PTS_BOTTOM);
        r.sample_a = '1; r.sample_b = '1;
        queue_req(r);
        r = make_req(taab_pkg::FUNC_DROP, 1'b1, PTS_BOTTOM + 64'd1);
        r.sample_a = '0; r.sample_b = '0;
        queue_req(r);
        queue_req(make_req(taab_pkg::FUNC_PUSH, 1'b1, PTS_BOTTOM));
        queue_req(make_req(taab_pkg::FUNC_READ, 1'b1, PTS_BOTTOM));
        queue_req(make_req(taab_pkg::FUNC_READ, 1'b1, PTS_BOTTOM + 64'd1));
        queue_req(make_req(taab_pkg::FUNC_READ, 1'b1, PTS_BOTTOM));
        queue_req(make_req(taab_pkg::FUNC_PUSH, 1'b1, 64'd100));
        queue_req(make_req(taab_pkg::FUNC_PUSH, 1'b1, 64'd101));
        queue_req(make_req(taab_pkg::FUNC_READ, 1'b1, 64'd101));
        queue_req(make_req(taab_pkg::FUNC_PUSH, 1'b1, 64'd50));
        queue_req(make_req(taab_pkg::FUNC_READ, 1'b1, PTS_TOP));
        queue_req(make_req(taab_pkg::FUNC_READ, 1'b1, 64'd200));
        wait_drained();

        // Small capacities expose full and eviction paths; zero acts as one
        write_capacity(11'd0);
        queue_req(make_req(taab_pkg::FUNC_PUSH, 1'b1, 64'd300));
        queue_req(make_req(taab_pkg::FUNC_PUSH, 1'b1, 64'd301));
        queue_req(make_req(taab_pkg::FUNC_DROP, 1'b1, 64'd302));
        wait_drained();
        write_capacity(11'd4);
        push_pts = 64'd303;
        read_pts = 64'd303;
        for (int i = 0; i < 8; i++) begin
            queue_req(make_req(taab_pkg::FUNC_DROP, 1'b1, push_pts));
            push_pts = push_pts + 1;
        end
        wait_drained();
        // Lowering the limit below the count forces a multi-frame eviction
        write_capacity(11'd1);
        queue_req(make_req(taab_pkg::FUNC_DROP, 1'b1, push_pts));
        push_pts = push_pts + 1;
        wait_drained();

        // Random phases through several limits, the extremes among them
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_capacity(11'd3);
                1: write_capacity(11'd2047);
                2: write_capacity(11'd1024);
                3: write_capacity(11'd1);
                default: write_capacity(CAP_W'($urandom_range(2, 40)));
            endcase
            if (ph == 2) begin
                // Fill the block while the receiver holds off
                rx_long_stall = 1'b1;
                for (int i = 0; i < 60; i++) add_random_req();
                while (!rx_stall_done || rx_stall_cnt > 0) @(posedge i_clk);
                rx_long_stall = 1'b0;
            end
            if (ph == 4) tx_quiet = 1'b1;
            if (ph == 4) rx_quiet = 1'b1;
            for (int i = 0; i < 320; i++) begin
                add_random_req();
                if (i == 150) begin
                    // pause the sender until every result is back
                    while (pending_reqs.size() > 0 || i_in_valid) @(posedge i_clk);
                    sender_hold = 1'b1;
                    while (expected_results.size() > 0) @(posedge i_clk);
                    sender_hold = 1'b0;
                end
                while (pending_reqs.size() > 8) @(posedge i_clk);
            end
            while (pending_reqs.size() > 0 || i_in_valid || expected_results.size() > 0)
                @(posedge i_clk);
            repeat (2 * DEPTH + 20) @(posedge i_clk);
        end

        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
